FILE: hw/rtl/stlag_pkg.sv
// Shared types, constants and defaults for the scrolled tile layer address generator.
package stlag_pkg;

  localparam int MAP_COLUMNS_C   = 32;
  localparam int MAP_ROWS_C      = 64;
  localparam int SCREEN_WIDTH_C  = 320;
  localparam int SCREEN_HEIGHT_C = 224;

  localparam int CODE_W    = 13;
  localparam int MAP_IDX_W = 11;
  localparam int ROM_W     = 21;
  localparam int SCROLL_W  = 16;
  localparam int OFF_W     = 4;
  localparam int COL_W     = 5;
  localparam int ROW_W     = 6;

  // A tile whose position is at or left of minus WRAP_LIMIT moves right by WRAP_SPAN.
  localparam logic [16:0] WRAP_LIMIT = 17'd192;
  localparam logic [7:0]  WRAP_SPAN_HI = 8'd1;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic {
    REG_SCROLL_X = 1'b0,
    REG_SCROLL_Y = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic                 kind;
    logic [MAP_IDX_W-1:0] map_index;
    logic [15:0]          map_word;
    logic [8:0]           pixel_x;
    logic [7:0]           pixel_y;
  } in_t;

  typedef struct packed {
    logic             covered;
    logic [ROM_W-1:0] rom_address;
  } out_t;

  typedef struct packed {
    logic [SCROLL_W-1:0] scroll_x;
    logic [SCROLL_W-1:0] scroll_y;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic [OFF_W-1:0]     row_off;
    logic [OFF_W-1:0]     col_off;
    logic [MAP_IDX_W-1:0] map_idx;
  } loc_t;

endpackage

FILE: hw/rtl/scrolled_tile_layer_address_gen_core.sv
// Top level of the scrolled background tile layer address generator.
//
// This block turns screen pixel queries into tile ROM byte addresses for a
// scrolled 16x16 tile background. An input transaction either writes one tile
// map entry (the low 13 bits of the word become the tile code) or queries one
// screen pixel; each query yields exactly one result transaction, each write
// none. After reset the tile map is cleared by a sweep over all
// MAP_COLUMNS_C*MAP_ROWS entries (2048 with the default size), one entry per
// cycle, during which in_stall_o is held high; APB configuration writes are
// taken throughout. Once the sweep is done the block accepts one transaction
// per clock while the result register is not stalled. A query's read of the
// tile map RAM, whose single read port sets the rate of one query per clock,
// is registered in the RAM and then in the result register. The scroll registers
// sit at byte address 0 (scroll_x) and 4 (scroll_y) and should be written
// only while no transaction is in flight.
module scrolled_tile_layer_address_gen_core import stlag_pkg::*; #(
  parameter int MAP_ROWS      = MAP_ROWS_C,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_C,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_C
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAP_COLUMNS_C * MAP_ROWS;
  localparam int AW    = $clog2(DEPTH);

  cfg_t cfg;
  loc_t loc;

  // Clearing sweep state.
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;

  // Lookup stage, aligned with the RAM read data.
  logic               s1_valid_q, s1_valid_d;
  logic               s1_hit_q;
  logic [OFF_W-1:0]   s1_row_off_q;
  logic [OFF_W-1:0]   s1_col_off_q;

  // Result register.
  logic out_valid_q, out_valid_d;
  out_t out_data_q, out_data_d;

  logic              advance;
  logic              accept;
  logic              is_query;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [CODE_W-1:0] ram_rdata;

  stlag_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  stlag_locate #(
    .MAP_ROWS      (MAP_ROWS),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_locate (
    .item_i (in_data_i),
    .cfg_i  (cfg),
    .loc_o  (loc)
  );

  // The whole pipeline moves together whenever the result register is free.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_busy_q || !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_query   = kind_e'(in_data_i.kind) == KIND_QUERY;

  // Writes beyond the map are dropped. The sweep owns the write port while busy.
  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = '0;
    end else begin
      ram_we    = accept && !is_query &&
                  (12'(in_data_i.map_index) < 12'(DEPTH));
      ram_waddr = in_data_i.map_index[AW-1:0];
      ram_wdata = in_data_i.map_word[CODE_W-1:0];
    end
  end

  assign ram_re = accept && is_query;

  stlag_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (loc.map_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      if (clr_idx_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + AW'(1);
      end
    end
  end

  // For a covered pixel the ROM address is the tile code, row offset and column offset side by side; else it is zero.
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (advance) begin
      s1_valid_d             = accept && is_query;
      out_valid_d            = s1_valid_q;
      out_data_d.covered     = s1_hit_q;
      out_data_d.rom_address = s1_hit_q ? {ram_rdata, s1_row_off_q, s1_col_off_q} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_idx_q   <= clr_idx_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_hit_q     <= loc.hit && is_query;
      s1_row_off_q <= loc.row_off;
      s1_col_off_q <= loc.col_off;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hw/rtl/stlag_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stlag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/stlag_cfg.sv
// APB register file holding the horizontal and vertical scroll values.
module stlag_cfg import stlag_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [SCROLL_W-1:0] scroll_x_q, scroll_x_d;
  logic [SCROLL_W-1:0] scroll_y_q, scroll_y_d;
  logic                wr_en;

  // Only the word select bit is decoded; the byte offset bits are ignored.
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    scroll_x_d = scroll_x_q;
    scroll_y_d = scroll_y_q;
    if (wr_en) begin
      case (reg_idx_e'(paddr[2]))
        REG_SCROLL_X: scroll_x_d = pwdata[SCROLL_W-1:0];
        REG_SCROLL_Y: scroll_y_d = pwdata[SCROLL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_x_q <= '0;
      scroll_y_q <= '0;
    end else begin
      scroll_x_q <= scroll_x_d;
      scroll_y_q <= scroll_y_d;
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_SCROLL_X: prdata = {16'd0, scroll_x_q};
      REG_SCROLL_Y: prdata = {16'd0, scroll_y_q};
      default:      prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign cfg_o.scroll_x = scroll_x_q;
  assign cfg_o.scroll_y = scroll_y_q;

endmodule

FILE: hw/rtl/stlag_locate.sv
// Finds the map entry and in-tile offsets of a queried screen pixel.
module stlag_locate import stlag_pkg::*; #(
  parameter int MAP_ROWS      = MAP_ROWS_C,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_C,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_C
) (
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output loc_t loc_o
);

  logic [16:0] sum_x;
  logic [16:0] sum_y;
  logic [16:0] col_base;
  logic        on_screen;
  logic        row_ok;
  logic        col_ok;

  assign on_screen = (10'(item_i.pixel_x) < 10'(SCREEN_WIDTH)) &&
                     (10'(item_i.pixel_y) < 10'(SCREEN_HEIGHT));

  // Vertical: the tile row is simply the scrolled line divided by the tile size.
  assign sum_y  = 17'(item_i.pixel_y) + 17'(cfg_i.scroll_y);
  assign row_ok = sum_y[16:4] < 13'(MAP_ROWS);

  // Horizontal: the scrolled column names the tile directly unless that tile
  // has wrapped, in which case the column one wrap span further right does.
  assign sum_x    = 17'(item_i.pixel_x) + 17'(cfg_i.scroll_x);
  assign col_base = 17'({sum_x[8:4], 4'd0}) + WRAP_LIMIT;
  assign col_ok   = ((sum_x[16:9] == 8'd0) && (col_base > 17'(cfg_i.scroll_x))) ||
                    ((sum_x[16:9] == WRAP_SPAN_HI) && (col_base <= 17'(cfg_i.scroll_x)));

  assign loc_o.hit     = on_screen && row_ok && col_ok;
  assign loc_o.row_off = sum_y[3:0];
  assign loc_o.col_off = sum_x[3:0];
  assign loc_o.map_idx = {sum_y[ROW_W+3:4], sum_x[COL_W+3:4]};

endmodule

FILE: hw/rtl/stlag_checker.sv
// Port-level checker for the tile layer address generator and its bind.
module stlag_checker import stlag_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_t         in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_t        out_data_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // A stalled input transaction stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input transaction changed");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result transaction changed");

  // An uncovered pixel always reports address zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.covered |-> out_data_o.rom_address == '0)
    else $error("uncovered result with nonzero address");

  // The map clearing sweep holds off input right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken before the tile map was cleared");

  // A scroll_x write is visible on the next read of that register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && !paddr[2] |=>
      (paddr[2] || (prdata == {16'd0, $past(pwdata[15:0])})))
    else $error("scroll_x readback mismatch");

endmodule

bind scrolled_tile_layer_address_gen_core stlag_checker u_stlag_checker (.*);
